FILE: rtl/core/wzas_pkg.sv
package wzas_pkg;
    localparam int FEATURE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int STAT_WIDTH        = 48;
    localparam int NCHAN             = 4;
    localparam int CFG_WIDTH         = 16;
    localparam int CFG_IDX_WIDTH     = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_BASELINE  = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_RATE     = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_BACK     = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_W_DUR      = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZDIV,
        S_ZACC,
        S_SDIV,
        S_MEAN,
        S_SQ,
        S_VAR,
        S_VDIV,
        S_SQRT,
        S_NEXT,
        S_QDIV,
        S_OUT
    } t_state;

    // serial divider request
    typedef struct packed {
        logic         start;
        logic [127:0] num;
        logic [63:0]  den;
    } t_div_req;
endpackage

FILE: rtl/core/weighted_zscore_anomaly_scorer.sv
// Weighted z-score anomaly scorer. Each transaction carries four unsigned
// Q22.10 features; the block scores it against per-feature running mean and
// sample deviation (Welford), folds the item into the statistics, then
// returns one score transaction. Work is sequential: one transaction at a
// time, input stalled from acceptance until the score transaction leaves.
// Every division goes through one shared 128-step bit-serial divider. From
// acceptance to the score: a z phase that divides each feature's distance
// from the mean by its deviation only when scores are valid and the
// deviation clears its floor, an update that per feature runs the mean step
// division and, once two items are in, the squaring, the variance multiply,
// the variance divide and the square root, and last the score divide
// (skipped if scores are not valid). Any output stall comes on top of this.
module weighted_zscore_anomaly_scorer #(
    parameter int FEATURE_WIDTH = wzas_pkg::FEATURE_WIDTH_DEF,
    parameter int COUNT_WIDTH   = wzas_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [FEATURE_WIDTH-1:0]          i_interval_ms,
    input  logic [FEATURE_WIDTH-1:0]          i_key_rate,
    input  logic [FEATURE_WIDTH-1:0]          i_backspace_ratio,
    input  logic [FEATURE_WIDTH-1:0]          i_compose_time_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [15:0]                       o_score,
    output logic                              o_score_valid,
    input  logic                              i_cfg_we,
    input  logic [wzas_pkg::CFG_IDX_WIDTH-1:0] i_cfg_index,
    input  logic [wzas_pkg::CFG_WIDTH-1:0]    i_cfg_data
);
    localparam int SW        = wzas_pkg::STAT_WIDTH;
    localparam int SHIFT     = SW - FEATURE_WIDTH;
    localparam int FRAC      = 10 + SHIFT;
    localparam logic [63:0] DEV_FLOOR = 64'(((128'd1 << FRAC) + 128'd999) / 128'd1000);
    localparam logic [63:0] Z_CLAMP   = 64'd1 << 26 << 16;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // configuration
    logic [7:0]  r_baseline;
    logic [15:0] r_w [wzas_pkg::NCHAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline <= 8'd5;
            r_w[0] <= 16'd22938;
            r_w[1] <= 16'd19661;
            r_w[2] <= 16'd9830;
            r_w[3] <= 16'd13107;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wzas_pkg::REG_BASELINE:   r_baseline <= i_cfg_data[7:0];
                wzas_pkg::REG_W_INTERVAL: r_w[0] <= i_cfg_data;
                wzas_pkg::REG_W_RATE:     r_w[1] <= i_cfg_data;
                wzas_pkg::REG_W_BACK:     r_w[2] <= i_cfg_data;
                wzas_pkg::REG_W_DUR:      r_w[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // statistics state
    logic [SW-1:0]          r_mean [wzas_pkg::NCHAN];
    logic [SW-1:0]          r_dev  [wzas_pkg::NCHAN];
    logic [COUNT_WIDTH-1:0] r_count;
    logic [SW-1:0]          r_x    [wzas_pkg::NCHAN];

    wzas_pkg::t_state r_state, n_state;
    logic [1:0]   r_ch;
    logic         r_vld;
    logic [63:0]  r_acc;     // weighted z sum
    logic [127:0] r_prod;    // dev squared
    logic [127:0] r_mcand;   // serial multiplier operands
    logic [63:0]  r_mplier;
    logic [6:0]   r_step;
    logic [SW-1:0] r_d1, r_nm;
    logic [63:0]  r_root;
    logic [63:0]  r_srem;    // square root partial remainder
    logic [127:0] r_var;
    logic         r_first;   // d1*d2 pass of S_VAR

    // division start pulses come from the datapath block below
    logic         r_dstart;
    logic [127:0] r_dnum;
    logic [63:0]  r_dden;

    wzas_pkg::t_div_req w_req;
    logic         w_ddone;
    logic [127:0] w_quot;

    always_comb begin
        w_req.start = r_dstart;
        w_req.num   = r_dnum;
        w_req.den   = r_dden;
    end

    wzas_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );

    logic [SW-1:0]          w_xc, w_mc, w_dc, w_d2, w_nm;
    logic [COUNT_WIDTH-1:0] w_n;
    logic                   w_zoff;
    logic [17:0]            w_wsum;
    logic                   w_qready;
    logic [65:0]            w_sr, w_st, w_sdif;
    logic [SW:0]            w_adiff;
    logic [63:0]            w_z;
    logic                   w_dgo;

    always_comb begin
        w_xc  = r_x[r_ch];
        w_mc  = r_mean[r_ch];
        w_dc  = r_dev[r_ch];
        w_n   = r_count;
        w_zoff = (r_count < COUNT_WIDTH'(2)) || (64'(w_dc) < DEV_FLOOR);
        w_wsum = 18'(r_w[0]) + 18'(r_w[1]) + 18'(r_w[2]) + 18'(r_w[3]);
        w_qready = w_ddone || !r_vld || (w_wsum == 18'd0);
        w_d2  = (w_xc >= r_nm) ? w_xc - r_nm : r_nm - w_xc;
        w_nm  = (w_xc >= w_mc) ? w_mc + w_quot[SW-1:0] : w_mc - w_quot[SW-1:0];
        w_adiff = (w_xc >= w_mc) ? {1'b0, w_xc - w_mc} : {1'b0, w_mc - w_xc};
        w_z = (w_quot > 128'(Z_CLAMP)) ? Z_CLAMP : w_quot[63:0];
        // digit-by-digit square root, two radicand bits per step
        w_sr   = {r_srem, r_var[127:126]};
        w_st   = {r_root, 2'b01};
        w_sdif = w_sr - w_st;
    end

    // divider start for the next cycle
    always_comb begin
        w_dgo = 1'b0;
        unique case (r_state)
            wzas_pkg::S_ZDIV: w_dgo = r_vld && !w_zoff;
            wzas_pkg::S_SDIV: w_dgo = 1'b1;
            wzas_pkg::S_VAR:  w_dgo = (r_step == 7'd63) && !r_first;
            wzas_pkg::S_QDIV: w_dgo = r_vld && (w_wsum != 18'd0);
            default: ;
        endcase
    end

    assign o_stall = (r_state != wzas_pkg::S_IDLE) || o_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wzas_pkg::S_IDLE: if (i_valid && !o_stall) n_state = wzas_pkg::S_ZDIV;
            wzas_pkg::S_ZDIV: n_state = wzas_pkg::S_ZACC;
            wzas_pkg::S_ZACC: if (w_ddone || !r_vld || w_zoff)
                                  n_state = (r_ch == 2'd3) ? wzas_pkg::S_SDIV
                                                           : wzas_pkg::S_ZDIV;
            wzas_pkg::S_SDIV: n_state = wzas_pkg::S_MEAN;
            wzas_pkg::S_MEAN: if (w_ddone) n_state = (r_count > COUNT_WIDTH'(1))
                                  ? wzas_pkg::S_SQ : wzas_pkg::S_NEXT;
            wzas_pkg::S_SQ:   if (r_step == 7'd63) n_state = wzas_pkg::S_VAR;
            wzas_pkg::S_VAR:  if (r_step == 7'd63 && !r_first) n_state = wzas_pkg::S_VDIV;
            wzas_pkg::S_VDIV: if (w_ddone) n_state = wzas_pkg::S_SQRT;
            wzas_pkg::S_SQRT: if (r_step == 7'd0) n_state = wzas_pkg::S_NEXT;
            wzas_pkg::S_NEXT: n_state = (r_ch == 2'd3) ? wzas_pkg::S_QDIV
                                                       : wzas_pkg::S_SDIV;
            wzas_pkg::S_QDIV: n_state = wzas_pkg::S_OUT;
            wzas_pkg::S_OUT:  if (w_qready) n_state = wzas_pkg::S_IDLE;
            default:          n_state = wzas_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= wzas_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid  <= 1'b0;
            r_count  <= '0;
            r_dstart <= 1'b0;
            for (int i = 0; i < wzas_pkg::NCHAN; i++) begin
                r_mean[i] <= '0;
                r_dev[i]  <= SW'(1) << FRAC;
            end
        end else begin
            r_dstart <= w_dgo;
            // score raised once the quotient is ready, held while stalled
            if (r_state == wzas_pkg::S_OUT && w_qready) begin
                o_valid       <= 1'b1;
                o_score_valid <= r_vld;
                o_score       <= (r_vld && w_wsum != 18'd0)
                                 ? ((w_quot > 128'hFFFF) ? 16'hFFFF : w_quot[15:0])
                                 : 16'd0;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                wzas_pkg::S_IDLE: if (i_valid && !o_stall) begin
                    r_x[0] <= SW'(i_interval_ms) << SHIFT;
                    r_x[1] <= SW'(i_key_rate) << SHIFT;
                    r_x[2] <= SW'(i_backspace_ratio) << SHIFT;
                    r_x[3] <= SW'(i_compose_time_ms) << SHIFT;
                    r_vld  <= (r_count >= COUNT_WIDTH'(r_baseline));
                    r_ch   <= 2'd0;
                    r_acc  <= '0;
                end
                wzas_pkg::S_ZDIV: begin
                    r_dnum   <= 128'(w_adiff) << 16;
                    r_dden   <= 64'(w_dc);
                end
                wzas_pkg::S_ZACC: if (w_ddone || !r_vld || w_zoff) begin
                    // z is clamped to 43 bits, weight is 16 bits
                    if (w_ddone) r_acc <= r_acc + {21'd0, w_z[42:0]} * {48'd0, r_w[r_ch]};
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd3) begin
                        if (r_count != CMAX) r_count <= r_count + COUNT_WIDTH'(1);
                    end
                end
                wzas_pkg::S_SDIV: begin
                    r_d1     <= w_adiff[SW-1:0];
                    r_dnum   <= 128'(w_adiff);
                    r_dden   <= 64'(w_n);
                end
                wzas_pkg::S_MEAN: if (w_ddone) begin
                    r_nm         <= w_nm;
                    r_mean[r_ch] <= w_nm;
                    r_prod   <= '0;
                    r_mcand  <= 128'(w_dc);
                    r_mplier <= 64'(w_dc);
                    r_step   <= '0;
                end
                wzas_pkg::S_SQ: begin
                    // shift-add dev*dev, one multiplier bit per cycle
                    if (r_mplier[0]) r_prod <= r_prod + r_mcand;
                    if (r_step == 7'd63) begin
                        r_mcand  <= 128'(r_d1);
                        r_mplier <= 64'(w_d2);
                        r_var    <= '0;
                        r_first  <= 1'b1;
                        r_step   <= '0;
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_step   <= r_step + 7'd1;
                    end
                end
                wzas_pkg::S_VAR: begin
                    // pass 1: d1*d2, pass 2: add dev^2*(n-2), both serial
                    if (r_mplier[0]) r_var <= r_var + r_mcand;
                    if (r_step == 7'd63) begin
                        r_step <= '0;
                        if (r_first) begin
                            r_mcand  <= r_prod;
                            r_mplier <= 64'(w_n) - 64'd2;
                            r_first  <= 1'b0;
                        end else begin
                            r_dnum <= r_mplier[0] ? r_var + r_mcand : r_var;
                            r_dden <= 64'(w_n) - 64'd1;
                        end
                    end else begin
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                        r_step   <= r_step + 7'd1;
                    end
                end
                wzas_pkg::S_VDIV: if (w_ddone) begin
                    r_var  <= w_quot;
                    r_root <= '0;
                    r_srem <= '0;
                    r_step <= 7'd63;
                end
                wzas_pkg::S_SQRT: begin
                    r_var  <= r_var << 2;
                    r_step <= r_step - 7'd1;
                    if (w_sr >= w_st) begin
                        r_srem <= w_sdif[63:0];
                        r_root <= {r_root[62:0], 1'b1};
                    end else begin
                        r_srem <= w_sr[63:0];
                        r_root <= {r_root[62:0], 1'b0};
                    end
                end
                wzas_pkg::S_NEXT: begin
                    if (r_count > COUNT_WIDTH'(1))
                        r_dev[r_ch] <= (r_root > 64'({SW{1'b1}})) ? {SW{1'b1}}
                                                                  : r_root[SW-1:0];
                    r_ch <= r_ch + 2'd1;
                end
                wzas_pkg::S_QDIV: begin
                    r_dnum <= 128'(r_acc);
                    r_dden <= 64'({w_wsum, 8'd0});
                end
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/core/wzas_div.sv
// restoring divider, one quotient bit per cycle
module wzas_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wzas_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [127:0]       o_quot
);
    logic [127:0] r_q, n_q;
    logic [64:0]  r_rem, n_rem;
    logic [63:0]  r_den;
    logic [7:0]   r_cnt;
    logic         r_busy;
    logic [64:0]  w_sh;

    always_comb begin
        w_sh  = {r_rem[63:0], r_q[127]};
        n_q   = {r_q[126:0], 1'b0};
        n_rem = w_sh;
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_req.start && r_busy && (r_cnt == 8'd127);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 8'd0;
                r_q    <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 8'd1;
                if (r_cnt == 8'd127) r_busy <= 1'b0;
            end
        end
    end
    assign o_quot = r_q;
endmodule
